// ===== src/cpid_pkg.sv =====
package cpid_pkg;

    localparam int GAIN_W    = 16;
    localparam int IN_W      = 16;
    localparam int OUT_W     = 14;
    localparam int ERR_W     = 18;
    localparam int DIFF_W    = 21;
    localparam int INTEG_W   = 32;
    localparam int INTEG_FRAC = 16;
    localparam int Q8_FRAC   = 8;
    localparam int LOUT_W    = 16;
    localparam int MA_W      = GAIN_W + 1;
    localparam int MB_W      = INTEG_W;
    localparam int PROD_W    = MA_W + MB_W;
    localparam int PLO_W     = 36;
    localparam int IG_W      = 44;
    localparam int TERM_W    = 36;
    localparam int ACC_W     = 54;
    localparam int CFG_IDX_W = 3;
    localparam int STATE_W   = 4;

    localparam logic [1:0] MODE_POS = 2'd0;
    localparam logic [1:0] MODE_INC = 2'd1;
    localparam logic [1:0] MODE_ANA = 2'd2;

    localparam logic [1:0] LOOP_SPEED  = 2'd0;
    localparam logic [1:0] LOOP_DOUBLE = 2'd1;
    localparam logic [1:0] LOOP_ANGLE  = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_MODE     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LOOP     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_OUTER_KP = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_OUTER_KI = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_OUTER_KD = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_INNER_KP = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_INNER_KI = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_INNER_KD = 3'd7;

    localparam logic [GAIN_W-1:0] INNER_KP_RST = 16'd1280;
    localparam logic [GAIN_W-1:0] INNER_KI_RST = 16'd26;

    localparam logic [STATE_W-1:0] ST_IDLE = 4'd0;
    localparam logic [STATE_W-1:0] ST_P    = 4'd1;
    localparam logic [STATE_W-1:0] ST_I    = 4'd2;
    localparam logic [STATE_W-1:0] ST_D    = 4'd3;
    localparam logic [STATE_W-1:0] ST_AI   = 4'd4;
    localparam logic [STATE_W-1:0] ST_AD   = 4'd5;
    localparam logic [STATE_W-1:0] ST_OUT  = 4'd6;
    localparam logic [STATE_W-1:0] ST_ERR  = 4'd7;
    localparam logic [STATE_W-1:0] ST_EMIT = 4'd8;

    typedef struct packed {
        logic [GAIN_W-1:0] kp;
        logic [GAIN_W-1:0] ki;
        logic [GAIN_W-1:0] kd;
    } t_gains;

    typedef struct packed {
        logic [STATE_W-1:0] state;
        logic               start;
        logic               inner;
        logic [1:0]         mode;
        logic               speed_only;
    } t_ctrl;

endpackage

// ===== src/cpid_mul.sv =====
module cpid_mul import cpid_pkg::*; (
    input  logic                     i_clk,
    input  logic                     i_en,
    input  logic signed [MA_W-1:0]   i_a,
    input  logic signed [MB_W-1:0]   i_b,
    output logic signed [PROD_W-1:0] o_prod
);

    logic signed [PROD_W-1:0] r_prod;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_prod <= PROD_W'(i_a) * PROD_W'(i_b);
        end
    end

    assign o_prod = r_prod;

endmodule

// ===== src/cpid_datapath.sv =====
module cpid_datapath import cpid_pkg::*; #(
    parameter int OUTPUT_LIMIT   = 5000,
    parameter int INTEGRAL_LIMIT = 2000,
    parameter int DT_SHIFT       = 10
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  t_ctrl                    i_ctrl,
    input  t_gains                   i_gains,
    input  logic signed [IN_W-1:0]   i_outer_target,
    input  logic signed [IN_W-1:0]   i_outer_measure,
    input  logic signed [IN_W-1:0]   i_inner_target,
    input  logic signed [IN_W-1:0]   i_inner_measure,
    output logic signed [LOUT_W-1:0] o_outer_out,
    output logic signed [LOUT_W-1:0] o_inner_out
);

    localparam logic signed [IG_W-1:0]   ILIM_Q16 =
        IG_W'(longint'(INTEGRAL_LIMIT) * 65536);
    localparam logic signed [PLO_W-1:0]  ILIM_Q8 =
        PLO_W'(longint'(INTEGRAL_LIMIT) * 256);
    localparam logic signed [ACC_W-1:0]  OLIM = ACC_W'(OUTPUT_LIMIT);
    localparam logic signed [ACC_W-1:0]  HALF_Q8 = ACC_W'(128);

    // per-loop state, index 0 outer, 1 inner
    logic signed [ERR_W-1:0]   r_prev  [2];
    logic signed [ERR_W-1:0]   r_prev2 [2];
    logic signed [INTEG_W-1:0] r_integ [2];
    logic signed [LOUT_W-1:0]  r_dacc  [2];
    logic signed [LOUT_W-1:0]  r_lout  [2];

    logic signed [IN_W-1:0]    r_it;
    logic signed [IN_W-1:0]    r_im;
    logic signed [ERR_W-1:0]   r_err;
    logic signed [ACC_W-1:0]   r_acc;
    logic signed [TERM_W-1:0]  r_term;

    logic                      lp;
    logic                      inc;
    logic                      ana;
    logic signed [DIFF_W-1:0]  e_x;
    logic signed [DIFF_W-1:0]  p_x;
    logic signed [DIFF_W-1:0]  q_x;
    logic signed [DIFF_W-1:0]  d1;
    logic signed [DIFF_W-1:0]  d2;
    logic                      mul_en;
    logic [GAIN_W-1:0]         mul_gain;
    logic signed [MA_W-1:0]    mul_a;
    logic signed [MB_W-1:0]    mul_b;
    logic signed [PROD_W-1:0]  prod;
    logic signed [PLO_W-1:0]   prod_lo;
    logic signed [IG_W-1:0]    ig_sum;
    logic signed [INTEG_W-1:0] ig_sat;
    logic signed [TERM_W-1:0]  i_term;
    logic signed [ACC_W-1:0]   acc_init;
    logic signed [ACC_W-1:0]   d_term;
    logic signed [ACC_W-1:0]   rnd;
    logic signed [LOUT_W-1:0]  lout;
    logic signed [ERR_W-1:0]   inner_err;

    assign lp  = i_ctrl.inner;
    assign inc = (i_ctrl.mode == MODE_INC);
    assign ana = (i_ctrl.mode == MODE_ANA);

    assign e_x = DIFF_W'(r_err);
    assign p_x = DIFF_W'(r_prev[lp]);
    assign q_x = DIFF_W'(r_prev2[lp]);
    assign d1  = e_x - p_x;
    assign d2  = e_x - (p_x <<< 1) + q_x;

    always_comb begin
        mul_en   = 1'b0;
        mul_gain = i_gains.kp;
        mul_b    = MB_W'(e_x);
        case (i_ctrl.state)
            ST_P: begin
                mul_en   = 1'b1;
                mul_gain = i_gains.kp;
                mul_b    = inc ? MB_W'(d1) : MB_W'(e_x);
            end
            ST_I: begin
                mul_en   = 1'b1;
                mul_gain = i_gains.ki;
                mul_b    = ana ? r_integ[lp] : MB_W'(e_x);
            end
            ST_D: begin
                mul_en   = 1'b1;
                mul_gain = i_gains.kd;
                mul_b    = inc ? MB_W'(d2) : MB_W'(d1);
            end
            default: begin
                mul_en   = 1'b0;
            end
        endcase
    end

    assign mul_a = $signed({1'b0, mul_gain});

    cpid_mul u_mul (
        .i_clk  (i_clk),
        .i_en   (mul_en),
        .i_a    (mul_a),
        .i_b    (mul_b),
        .o_prod (prod)
    );

    assign prod_lo = $signed(prod[PLO_W-1:0]);

    // integral update: analog in the P step, positional in the D step
    always_comb begin
        if (i_ctrl.state == ST_P) begin
            ig_sum = IG_W'(r_integ[lp]) + (IG_W'(r_err) <<< (INTEG_FRAC - DT_SHIFT));
        end else begin
            ig_sum = IG_W'(r_integ[lp]) + (IG_W'(prod_lo) <<< Q8_FRAC);
        end
        if (ig_sum > ILIM_Q16) begin
            ig_sat = INTEG_W'(ILIM_Q16);
        end else if (ig_sum < -ILIM_Q16) begin
            ig_sat = INTEG_W'(-ILIM_Q16);
        end else begin
            ig_sat = INTEG_W'(ig_sum);
        end
    end

    always_comb begin
        if (inc) begin
            if (prod_lo > ILIM_Q8) begin
                i_term = TERM_W'(ILIM_Q8);
            end else if (prod_lo < -ILIM_Q8) begin
                i_term = TERM_W'(-ILIM_Q8);
            end else begin
                i_term = TERM_W'(prod_lo);
            end
        end else if (ana) begin
            i_term = TERM_W'(prod >>> INTEG_FRAC);
        end else begin
            i_term = TERM_W'(ig_sat >>> Q8_FRAC);
        end
    end

    assign acc_init = ACC_W'(prod) + (inc ? (ACC_W'(r_dacc[lp]) <<< Q8_FRAC) : '0);
    assign d_term   = ana ? (ACC_W'(prod) <<< DT_SHIFT) : ACC_W'(prod);

    always_comb begin
        rnd = (r_acc + HALF_Q8) >>> Q8_FRAC;
        if (rnd > OLIM) begin
            lout = LOUT_W'(OLIM);
        end else if (rnd < -OLIM) begin
            lout = LOUT_W'(-OLIM);
        end else begin
            lout = LOUT_W'(rnd);
        end
    end

    assign inner_err = i_ctrl.speed_only ? (ERR_W'(r_it) - ERR_W'(r_im))
                                         : (ERR_W'(r_lout[1'b0]) - ERR_W'(r_im));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < 2; k++) begin
                r_prev[k]  <= '0;
                r_prev2[k] <= '0;
                r_integ[k] <= '0;
                r_dacc[k]  <= '0;
            end
        end else begin
            case (i_ctrl.state)
                ST_P: begin
                    if (ana) begin
                        r_integ[lp] <= ig_sat;
                    end
                end
                ST_D: begin
                    if (i_ctrl.mode == MODE_POS) begin
                        r_integ[lp] <= ig_sat;
                    end
                end
                ST_OUT: begin
                    r_prev[lp] <= r_err;
                    if (inc) begin
                        r_prev2[lp] <= r_prev[lp];
                        r_dacc[lp]  <= lout;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.start) begin
            r_it  <= i_inner_target;
            r_im  <= i_inner_measure;
            r_err <= ERR_W'(i_outer_target) - ERR_W'(i_outer_measure);
        end
        case (i_ctrl.state)
            ST_I:    r_acc  <= acc_init;
            ST_D:    r_term <= i_term;
            ST_AI:   r_acc  <= r_acc + ACC_W'(r_term);
            ST_AD:   r_acc  <= r_acc + d_term;
            ST_OUT:  r_lout[lp] <= lout;
            ST_ERR:  r_err  <= inner_err;
            default: begin
            end
        endcase
    end

    assign o_outer_out = r_lout[1'b0];
    assign o_inner_out = r_lout[1'b1];

endmodule

// ===== src/cascaded_pid_controller_core.sv =====
// Cascaded PID controller: an outer (angle) loop whose output feeds the inner
// (speed) loop, in positional, incremental or analog form; positional mode can
// also run the speed loop alone. Both loops run in turn on one shared 17x32
// multiplier under a small sequencer, six steps per loop plus one step to form
// the inner error and one to post the result. The result waits in an output
// register and the next request is taken meanwhile; a second result stalls
// only until the first is taken. Gains are unsigned Q8.8; outputs saturate at
// OUTPUT_LIMIT and integral terms at INTEGRAL_LIMIT, shared by both loops. The
// user must write registers through i_cfg_we / i_cfg_index / i_cfg_data only
// while the core is idle; the core itself does not enforce this.
module cascaded_pid_controller_core import cpid_pkg::*; #(
    parameter int OUTPUT_LIMIT   = 5000,
    parameter int INTEGRAL_LIMIT = 2000,
    parameter int DT_SHIFT       = 10
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [CFG_IDX_W-1:0]        i_cfg_index,
    input  logic [GAIN_W-1:0]           i_cfg_data,
    input  logic                        i_in_valid,
    output logic                        o_in_ready,
    input  logic signed [IN_W-1:0]      i_outer_target,
    input  logic signed [IN_W-1:0]      i_outer_measure,
    input  logic signed [IN_W-1:0]      i_inner_target,
    input  logic signed [IN_W-1:0]      i_inner_measure,
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output logic signed [OUT_W-1:0]     o_drive,
    output logic signed [OUT_W-1:0]     o_outer_drive
);

    logic [1:0]               r_mode;
    logic [1:0]               r_lsel;
    t_gains                   r_outer_g;
    t_gains                   r_inner_g;
    logic [STATE_W-1:0]       r_state;
    logic [STATE_W-1:0]       n_state;
    logic                     r_inner;
    logic                     n_inner;
    logic                     r_out_valid;
    logic                     n_out_valid;
    logic signed [OUT_W-1:0]  r_drive;
    logic signed [OUT_W-1:0]  r_outer_drive;

    logic                     in_fire;
    logic                     emit_fire;
    logic                     mode_ok;
    t_ctrl                    ctrl;
    logic signed [LOUT_W-1:0] outer_out;
    logic signed [LOUT_W-1:0] inner_out;

    assign mode_ok   = (r_mode == MODE_POS) || (r_mode == MODE_INC) ||
                       (r_mode == MODE_ANA);
    assign o_in_ready = (r_state == ST_IDLE);
    assign in_fire   = i_in_valid && o_in_ready;
    assign emit_fire = (r_state == ST_EMIT) && (!r_out_valid || i_out_ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode    <= MODE_POS;
            r_lsel    <= LOOP_SPEED;
            r_outer_g <= '0;
            r_inner_g <= '{kp: INNER_KP_RST, ki: INNER_KI_RST, kd: '0};
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_MODE:     r_mode       <= i_cfg_data[1:0];
                REG_LOOP:     r_lsel       <= i_cfg_data[1:0];
                REG_OUTER_KP: r_outer_g.kp <= i_cfg_data;
                REG_OUTER_KI: r_outer_g.ki <= i_cfg_data;
                REG_OUTER_KD: r_outer_g.kd <= i_cfg_data;
                REG_INNER_KP: r_inner_g.kp <= i_cfg_data;
                REG_INNER_KI: r_inner_g.ki <= i_cfg_data;
                REG_INNER_KD: r_inner_g.kd <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        n_state = r_state;
        n_inner = r_inner;
        case (r_state)
            ST_IDLE: begin
                if (in_fire) begin
                    n_state = mode_ok ? ST_P : ST_EMIT;
                    n_inner = 1'b0;
                end
            end
            ST_P:   n_state = ST_I;
            ST_I:   n_state = ST_D;
            ST_D:   n_state = ST_AI;
            ST_AI:  n_state = ST_AD;
            ST_AD:  n_state = ST_OUT;
            ST_OUT: n_state = r_inner ? ST_EMIT : ST_ERR;
            ST_ERR: begin
                n_state = ST_P;
                n_inner = 1'b1;
            end
            ST_EMIT: begin
                if (emit_fire) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    assign n_out_valid = (r_out_valid && !i_out_ready) || emit_fire;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_inner     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_inner     <= n_inner;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit_fire) begin
            if (!mode_ok) begin
                r_drive       <= '0;
                r_outer_drive <= '0;
            end else begin
                r_outer_drive <= OUT_W'(outer_out);
                if ((r_mode == MODE_POS) && (r_lsel == LOOP_ANGLE)) begin
                    r_drive <= OUT_W'(outer_out);
                end else begin
                    r_drive <= OUT_W'(inner_out);
                end
            end
        end
    end

    assign ctrl.state      = r_state;
    assign ctrl.start      = in_fire;
    assign ctrl.inner      = r_inner;
    assign ctrl.mode       = r_mode;
    assign ctrl.speed_only = (r_mode == MODE_POS) &&
                             (r_lsel != LOOP_DOUBLE) && (r_lsel != LOOP_ANGLE);

    cpid_datapath #(
        .OUTPUT_LIMIT   (OUTPUT_LIMIT),
        .INTEGRAL_LIMIT (INTEGRAL_LIMIT),
        .DT_SHIFT       (DT_SHIFT)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_ctrl          (ctrl),
        .i_gains         (r_inner ? r_inner_g : r_outer_g),
        .i_outer_target  (i_outer_target),
        .i_outer_measure (i_outer_measure),
        .i_inner_target  (i_inner_target),
        .i_inner_measure (i_inner_measure),
        .o_outer_out     (outer_out),
        .o_inner_out     (inner_out)
    );

    assign o_out_valid   = r_out_valid;
    assign o_drive       = r_drive;
    assign o_outer_drive = r_outer_drive;

endmodule
